// ----- rtl/grid_line_of_sight_ray_march_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid line-of-sight ray march
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_RAY_MARCH_MACROS_SVH
`define GRID_LINE_OF_SIGHT_RAY_MARCH_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GLOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the same cycle.
`define GLOS_IMPLY(lbl, ante, cons, msg) \
  `GLOS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/glos_pkg.sv -----
// ----------------------------------------------------------------------------
// glos_pkg
// Types, constants and helper functions shared by the ray march modules.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Grid geometry.
  localparam int MAX_DIM   = 32;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  // Field and position widths. A position is a start plus at most one step
  // beyond an in-grid cell, so two extra bits keep it from wrapping.
  localparam int FLD_W = 7;
  localparam int POS_W = FLD_W + 2;

  // Configuration port.
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_RESET = 32;

  // Command queue.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT = 1'b0,
    CFG_WIDTH  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_WAIT  = 2'd2
  } back_state_t;

  // Effective grid size seen by the front and back.
  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
  } dims_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_t                      op;
    logic signed [FLD_W-1:0]  row;
    logic signed [FLD_W-1:0]  col;
    logic signed [FLD_W-1:0]  step_row;
    logic signed [FLD_W-1:0]  step_col;
    logic                     tbit;
  } cmd_t;

  // Clamp a size register to the map's capacity.
  function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (int'(d) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(d);
    end
    return res;
  endfunction

  // True when a position lies inside the rows and columns in use.
  function automatic logic in_grid(logic signed [POS_W-1:0] r,
                                   logic signed [POS_W-1:0] c,
                                   dims_t d);
    logic signed [POS_W-1:0] hs;
    logic signed [POS_W-1:0] ws;
    hs = POS_W'(d.height);
    ws = POS_W'(d.width);
    return !r[POS_W-1] && (r < hs) && !c[POS_W-1] && (c < ws);
  endfunction

  // Map address of an in-grid cell.
  function automatic logic [ADDR_W-1:0] map_addr(logic signed [POS_W-1:0] r,
                                                 logic signed [POS_W-1:0] c);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(r[IDX_W-1:0]) * ADDR_W'(MAX_DIM));
    return ADDR_W'(base + ADDR_W'(c[IDX_W-1:0]));
  endfunction

endpackage

// ----- rtl/glos_front.sv -----
// ----------------------------------------------------------------------------
// glos_front
// Accepts input items, drops writes outside the grid and queues the rest.
// ----------------------------------------------------------------------------
module glos_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic signed [glos_pkg::FLD_W-1:0] in_row_pos,
  input  logic signed [glos_pkg::FLD_W-1:0] in_col_pos,
  input  logic signed [glos_pkg::FLD_W-1:0] in_step_row,
  input  logic signed [glos_pkg::FLD_W-1:0] in_step_col,
  input  logic                            in_target_bit,
  input  glos_pkg::dims_t                 dims,
  input  logic                            q_full,
  output logic                            q_push,
  output glos_pkg::cmd_t                  q_cmd
);
  import glos_pkg::*;

  logic xfer;
  logic cell_ok;

  // An item transfers whenever the queue has room.
  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // A write to a cell outside the grid is dropped here.
  assign cell_ok = in_grid(POS_W'(in_row_pos), POS_W'(in_col_pos), dims);

  always_comb begin
    q_cmd.op       = op_t'(in_operation);
    q_cmd.row      = in_row_pos;
    q_cmd.col      = in_col_pos;
    q_cmd.step_row = in_step_row;
    q_cmd.step_col = in_step_col;
    q_cmd.tbit     = in_target_bit;
  end

  assign q_push = xfer && ((op_t'(in_operation) == OP_QUERY) || cell_ok);

endmodule

// ----- rtl/glos_queue.sv -----
// ----------------------------------------------------------------------------
// glos_queue
// Short first-in first-out queue of commands between the front and back.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_ray_march_macros.svh"

module glos_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  glos_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output glos_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import glos_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `GLOS_ASSERT(a_cnt_bound, cnt_r <= QCNT_W'(QDEPTH), "queue count exceeds depth")
  `GLOS_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
  `GLOS_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")

endmodule

// ----- rtl/glos_back.sv -----
// ----------------------------------------------------------------------------
// glos_back
// Executes queued commands: writes map bits and marches query rays.
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_ray_march_macros.svh"

module glos_back (
  input  logic           clk,
  input  logic           rst_n,
  input  glos_pkg::dims_t dims,
  input  logic           q_empty,
  input  glos_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_sees_target
);
  import glos_pkg::*;

  back_state_t state_r;
  back_state_t state_nxt;

  // Ray registers.
  logic signed [POS_W-1:0] row_r;
  logic signed [POS_W-1:0] col_r;
  logic signed [FLD_W-1:0] drow_r;
  logic signed [FLD_W-1:0] dcol_r;
  logic                    moving_r;

  // Target map with one write and one registered read port.
  logic                    map_r [MAP_DEPTH];
  logic                    rd_bit_r;

  logic                    out_valid_r;
  logic                    out_hit_r;

  // Control decoded from the state.
  logic                    slot_free;
  logic                    pos_in;
  logic                    load;
  logic                    advance;
  logic                    map_we;
  logic                    rd_en;
  logic                    finish;
  logic                    hit;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;

  assign slot_free = !out_valid_r || out_ready;
  assign pos_in    = in_grid(row_r, col_r, dims);
  assign wr_addr   = map_addr(POS_W'(q_cmd.row), POS_W'(q_cmd.col));
  assign rd_addr   = map_addr(row_r, col_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && (q_cmd.op == OP_QUERY)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pos_in) begin
          state_nxt = ST_WAIT;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (rd_bit_r || !moving_r) begin
          if (slot_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop   = 1'b0;
    load    = 1'b0;
    map_we  = 1'b0;
    rd_en   = 1'b0;
    advance = 1'b0;
    finish  = 1'b0;
    hit     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          load   = (q_cmd.op == OP_QUERY);
          map_we = (q_cmd.op == OP_WRITE);
        end
      end
      ST_CHECK: begin
        if (pos_in) begin
          rd_en = 1'b1;
        end else begin
          finish = slot_free;
        end
      end
      ST_WAIT: begin
        if (rd_bit_r || !moving_r) begin
          finish = slot_free;
          hit    = rd_bit_r;
        end else begin
          advance = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ray position: the first step is taken at load time.
  always_ff @(posedge clk) begin
    if (load) begin
      row_r    <= POS_W'(POS_W'(q_cmd.row) + POS_W'(q_cmd.step_row));
      col_r    <= POS_W'(POS_W'(q_cmd.col) + POS_W'(q_cmd.step_col));
      drow_r   <= q_cmd.step_row;
      dcol_r   <= q_cmd.step_col;
      moving_r <= (q_cmd.step_row != '0) || (q_cmd.step_col != '0);
    end else if (advance) begin
      row_r <= POS_W'(row_r + POS_W'(drow_r));
      col_r <= POS_W'(col_r + POS_W'(dcol_r));
    end
    if (finish) begin
      out_hit_r <= hit;
    end
  end

  // Map memory.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_r[wr_addr] <= q_cmd.tbit;
    end
    if (rd_en) begin
      rd_bit_r <= map_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sees_target = out_hit_r;

  `GLOS_ASSERT(a_no_overwrite, !(finish && out_valid_r && !out_ready),
               "result finished while output still occupied")
  `GLOS_IMPLY(a_wait_after_read, (state_r == ST_WAIT) && ($past(state_r) != ST_WAIT),
              $past(rd_en), "wait state entered without a map read")
  `GLOS_IMPLY(a_pop_in_idle, q_pop, state_r == ST_IDLE, "queue popped outside idle")
  `GLOS_IMPLY(a_read_in_grid, rd_en, pos_in, "map read outside the grid")

endmodule

// ----- rtl/grid_line_of_sight_ray_march.sv -----
// Map writes pass through the command queue and are stored when the engine pops them
// in its idle state. A query loads its start plus one step, then reads and tests each
// in-grid cell in turn; the result is offered when the ray stops on a cell it read or
// leaves the grid. The engine pops one write per cycle while idle; a query keeps it
// busy in the read-then-test loop on the single map read port until it is answered.
// Reset (rst_n, synchronous, active low) empties the queue, drops any result and
// sets both grid sizes to 32; the target map is not cleared.
// ----------------------------------------------------------------------------
// grid_line_of_sight_ray_march
// Top level: size registers, front classifier, command queue and ray engine.
// ----------------------------------------------------------------------------
module grid_line_of_sight_ray_march (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_row_pos,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_col_pos,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_step_row,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_step_col,
  input  logic                                in_target_bit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_sees_target,
  input  logic                                cfg_wr_en,
  input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]          cfg_data
);
  import glos_pkg::*;

  logic [CFG_W-1:0] grid_height_r;
  logic [CFG_W-1:0] grid_width_r;
  dims_t            dims;

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_height_r <= CFG_W'(CFG_RESET);
      grid_width_r  <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEIGHT: grid_height_r <= cfg_data;
        CFG_WIDTH:  grid_width_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sizes above the map capacity act as the capacity.
  assign dims.height = eff_dim(grid_height_r);
  assign dims.width  = eff_dim(grid_width_r);

  glos_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_row_pos    (in_row_pos),
    .in_col_pos    (in_col_pos),
    .in_step_row   (in_step_row),
    .in_step_col   (in_step_col),
    .in_target_bit (in_target_bit),
    .dims          (dims),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  glos_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  glos_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dims            (dims),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sees_target (out_sees_target)
  );

endmodule

// ----- tb/sv/grid_line_of_sight_ray_march_checker.sv -----
// ----------------------------------------------------------------------------
// Line-of-sight result checker
// Watches the input, result and register ports of the ray march block. It
// keeps its own copy of the grid size and the target map, traces every
// accepted query, and compares each result transfer with the oldest answer
// still owed.
// ----------------------------------------------------------------------------
module grid_line_of_sight_ray_march_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_row_pos,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_col_pos,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_step_row,
  input  logic signed [glos_pkg::FLD_W-1:0]   in_step_col,
  input  logic                                in_target_bit,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_sees_target,
  input  logic                                cfg_wr_en,
  input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glos_pkg::CFG_W-1:0]          cfg_data,
  output int                                  mismatch_count,
  output int                                  results_pending
);
  import glos_pkg::*;

  // Shadow copies of the size registers and of the target map.
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  bit               target_map [MAP_DEPTH];
  bit               sight_queue [$];

  // A size register larger than the map acts as the full map size.
  function automatic int usable_dim(logic [CFG_W-1:0] d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic bit on_grid(int r, int c);
    return (r >= 0) && (r < usable_dim(rows_reg)) && (c >= 0) && (c < usable_dim(cols_reg));
  endfunction

  // March from the start at least once, then keep going through empty
  // in-grid cells while the step is nonzero.
  function automatic bit trace_sight(int r, int c, int dr, int dc);
    bit moving;
    moving = (dr != 0) || (dc != 0);
    do begin
      r += dr;
      c += dc;
    end while (moving && on_grid(r, c) && !target_map[r * MAX_DIM + c]);
    return on_grid(r, c) && target_map[r * MAX_DIM + c];
  endfunction

  always @(posedge clk) begin : watch
    bit owed;
    if (!rst_n) begin
      rows_reg = CFG_W'(CFG_RESET);
      cols_reg = CFG_W'(CFG_RESET);
      sight_queue.delete();
    end else begin
      // A result transfer always answers an earlier query, so compare first.
      if (out_valid && out_ready) begin
        if (sight_queue.size() == 0) begin
          $display("%0t: result with no query pending: expected none, got sees_target=%0b",
                   $time, out_sees_target);
          mismatch_count++;
        end else begin
          owed = sight_queue.pop_front();
          if (out_sees_target !== owed) begin
            $display("%0t: sees_target mismatch: expected %0b, got %0b",
                     $time, owed, out_sees_target);
            mismatch_count++;
          end
        end
      end

      // Input transfer: writes update the map, queries owe one answer.
      if (in_valid && in_ready) begin
        if (in_operation == OP_QUERY) begin
          sight_queue.push_back(trace_sight(int'(in_row_pos), int'(in_col_pos),
                                            int'(in_step_row), int'(in_step_col)));
        end else if (on_grid(int'(in_row_pos), int'(in_col_pos))) begin
          target_map[int'(in_row_pos) * MAX_DIM + int'(in_col_pos)] = in_target_bit;
        end
      end

      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HEIGHT: rows_reg = cfg_data;
          CFG_WIDTH:  cols_reg = cfg_data;
          default:    ;
        endcase
      end
    end
    results_pending = sight_queue.size();
  end

endmodule

// ----- tb/sv/grid_line_of_sight_ray_march_tb.sv -----
// ----------------------------------------------------------------------------
// Grid line-of-sight ray march testbench
// Fills an L-shaped part of the target map once (all rows of the first
// columns, all columns of the first rows), runs a short directed list of edge
// cases, then sends random writes and ray queries under a series of grid
// sizes that stay inside the filled part, including zero and oversized
// registers. The sender works in bursts and the receiver stalls on its own
// pattern; the checker scores every result.
// ----------------------------------------------------------------------------
module grid_line_of_sight_ray_march_tb;
  import glos_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 48;
  localparam int FILL_SPAN     = 8;
  localparam int LIMIT_CYCLES  = 1_000_000;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_PERIODIC
  } drain_mode_t;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic                     in_operation    = 1'b0;
  logic signed [FLD_W-1:0]  in_row_pos      = '0;
  logic signed [FLD_W-1:0]  in_col_pos      = '0;
  logic signed [FLD_W-1:0]  in_step_row     = '0;
  logic signed [FLD_W-1:0]  in_step_col     = '0;
  logic                     in_target_bit   = 1'b0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic                     out_sees_target;
  logic                     cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index       = '0;
  logic [CFG_W-1:0]         cfg_data        = '0;

  int          mismatch_count;
  int          results_pending;
  int          writes_sent    = 0;
  int          queries_sent   = 0;
  int          settings_used  = 0;
  int          grid_rows      = MAX_DIM;
  int          grid_cols      = MAX_DIM;
  drain_mode_t drain_mode     = DRAIN_FREE;
  int          drain_count    = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  grid_line_of_sight_ray_march i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_row_pos      (in_row_pos),
    .in_col_pos      (in_col_pos),
    .in_step_row     (in_step_row),
    .in_step_col     (in_step_col),
    .in_target_bit   (in_target_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sees_target (out_sees_target),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  grid_line_of_sight_ray_march_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_row_pos      (in_row_pos),
    .in_col_pos      (in_col_pos),
    .in_step_row     (in_step_row),
    .in_step_col     (in_step_col),
    .in_target_bit   (in_target_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sees_target (out_sees_target),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Receiver: switches among free flow, coin-flip stalls and a one-in-four
  // pattern, each for a random stretch of cycles.
  always @(posedge clk) begin
    if (drain_count == 0) begin
      drain_mode  <= drain_mode_t'($urandom_range(0, 2));
      drain_count <= $urandom_range(16, 96);
    end else begin
      drain_count <= drain_count - 1;
    end
    case (drain_mode)
      DRAIN_FREE:   out_ready <= 1'b1;
      DRAIN_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
      default:      out_ready <= (drain_count % 4 == 0);
    endcase
  end

  // Holds one item on the input until its transfer.
  task automatic send_item(op_t op, int r, int c, int dr, int dc, bit tbit);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_row_pos    <= FLD_W'(r);
    in_col_pos    <= FLD_W'(c);
    in_step_row   <= FLD_W'(dr);
    in_step_col   <= FLD_W'(dc);
    in_target_bit <= tbit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_QUERY) queries_sent++;
    else writes_sent++;
  endtask

  // Stops sending and waits for every owed answer to come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  // Size registers change only with the block idle; trailing map writes get
  // time to land before the new size applies.
  task automatic set_grid(int h, int w);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    grid_rows = (h > MAX_DIM) ? MAX_DIM : h;
    grid_cols = (w > MAX_DIM) ? MAX_DIM : w;
    settings_used++;
  endtask

  function automatic int any_field();
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  // Mostly just around the grid, sometimes anywhere in the field range.
  function automatic int near_grid(int n);
    if ($urandom_range(0, 4) == 0) return any_field();
    return int'($urandom_range(0, n + 3)) - 2;
  endfunction

  function automatic int ray_step();
    if ($urandom_range(0, 4) == 0) return any_field();
    return int'($urandom_range(0, 6)) - 3;
  endfunction

  task automatic random_item();
    int dr;
    int dc;
    dr = ray_step();
    dc = ray_step();
    if ($urandom_range(0, 9) == 0) begin
      dr = 0;
      dc = 0;
    end
    if ($urandom_range(0, 99) < 35) begin
      send_item(OP_WRITE, near_grid(grid_rows), near_grid(grid_cols), dr, dc,
                $urandom_range(0, 4) == 0);
    end else begin
      send_item(OP_QUERY, near_grid(grid_rows), near_grid(grid_cols), dr, dc,
                $urandom_range(0, 1) == 1);
    end
  endtask

  // One grid setting: bursts of random items with random gaps, merged
  // bursts, and now and then a full drain.
  task automatic random_phase(int h, int w);
    int sent;
    int burst;
    set_grid(h, w);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
        random_item();
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        wait_drained();
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Write every cell that a later grid size can reach, so no query ever
    // reads one that was never written: first all rows of the narrow
    // columns under an oversized height, then the rest of the short rows
    // under an oversized width.
    set_grid(63, FILL_SPAN);
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < FILL_SPAN; c++) begin
        send_item(OP_WRITE, r, c, any_field(), any_field(), $urandom_range(0, 7) == 0);
      end
    end
    set_grid(FILL_SPAN, 40);
    for (int r = 0; r < FILL_SPAN; r++) begin
      for (int c = FILL_SPAN; c < MAX_DIM; c++) begin
        send_item(OP_WRITE, r, c, any_field(), any_field(), $urandom_range(0, 7) == 0);
      end
    end
    set_grid(63, FILL_SPAN);

    // Directed: corners, writes just outside and far outside the grid,
    // zero steps, extreme steps and starts outside the grid.
    send_item(OP_WRITE, 0, 0, 0, 0, 1'b1);
    send_item(OP_WRITE, 31, 7, 63, -64, 1'b1);
    send_item(OP_WRITE, -64, -64, 0, 0, 1'b1);
    send_item(OP_WRITE, 63, 63, 0, 0, 1'b1);
    send_item(OP_WRITE, 32, 0, 0, 0, 1'b1);
    send_item(OP_WRITE, 0, 8, 0, 0, 1'b1);
    send_item(OP_QUERY, 0, 0, 0, 0, 1'b0);
    send_item(OP_QUERY, 5, 5, 0, 0, 1'b1);
    send_item(OP_QUERY, -64, 63, 0, 0, 1'b0);
    send_item(OP_QUERY, -1, -1, 1, 1, 1'b0);
    send_item(OP_QUERY, 32, 8, -1, -1, 1'b0);
    send_item(OP_QUERY, -64, -64, 63, 63, 1'b1);
    send_item(OP_QUERY, 63, 63, -64, -64, 1'b0);
    send_item(OP_QUERY, 10, 10, 63, -64, 1'b0);
    send_item(OP_QUERY, 0, 5, 0, 1, 1'b0);
    send_item(OP_QUERY, 31, 0, -1, 0, 1'b0);
    send_item(OP_WRITE, 0, 0, 1, 1, 1'b0);
    send_item(OP_QUERY, -1, -1, 1, 1, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 0, 1'b1);
    send_item(OP_QUERY, 16, 0, 0, 1, 1'b0);
    send_item(OP_QUERY, 0, 7, 1, -1, 1'b0);

    // Random items under a range of sizes: small square, single cell, empty
    // rows or columns, odd sizes, oversized, single row and column, then
    // random.
    random_phase(FILL_SPAN, FILL_SPAN);
    random_phase(1, 1);
    random_phase(0, 7);
    random_phase(9, 0);
    random_phase(17, 5);
    random_phase(63, FILL_SPAN);
    random_phase(1, 32);
    random_phase(32, 1);
    random_phase(5, 63);
    random_phase($urandom_range(0, 63), $urandom_range(0, FILL_SPAN));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d map writes and %0d ray queries over %0d grid settings.",
             writes_sent, queries_sent, settings_used);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout well beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timeout with %0d answers still owed.", results_pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/glos_pkg.sv
rtl/glos_front.sv
rtl/glos_queue.sv
rtl/glos_back.sv
rtl/grid_line_of_sight_ray_march.sv
tb/sv/grid_line_of_sight_ray_march_checker.sv
tb/sv/grid_line_of_sight_ray_march_tb.sv
